FILE: hw/rtl/gbn_pkg.sv
// Package: shared types, request codes and constants for the Go-Back-N sender.
`default_nettype none
package gbn_pkg;

  localparam int unsigned WindowDepthDefault = 16;
  localparam logic [23:0] QOne = 24'h010000;

  typedef enum logic [2:0] {
    REQ_SEND  = 3'd0,
    REQ_ACK   = 3'd1,
    REQ_TIMER = 3'd2,
    REQ_LOSS  = 3'd3,
    REQ_RTT   = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    CFG_INIT_TIMEOUT = 3'd0,
    CFG_MAX_TIMEOUT  = 3'd1,
    CFG_SSTHRESH     = 3'd2,
    CFG_ADD_STEP     = 3'd3,
    CFG_ALPHA        = 3'd4,
    CFG_BETA         = 3'd5
  } cfg_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] seq_value;
    logic [31:0] now_us;
  } req_t;

  typedef struct packed {
    logic        may_send;
    logic [7:0]  window_now;
    logic        resend_valid;
    logic [15:0] resend_seq;
    logic [19:0] timeout_now_ms;
    logic [23:0] cwnd_fixed;
    logic        slow_start_on;
    logic [7:0]  held_count;
    logic        send_dropped;
  } rsp_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] data;
  } cfg_t;

endpackage
`default_nettype wire

FILE: hw/rtl/gbn_divu.sv
// Module: restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module gbn_divu #(
  parameter int unsigned NUM_W = 40,
  parameter int unsigned DEN_W = 24
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [NUM_W-1:0]      quo
);
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] rem_shift;
  logic [DEN_W:0]   part;
  logic [DEN_W-1:0] dvs;
  logic [CNT_W-1:0] count;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;

  always_comb begin
    trial = {part[DEN_W-1:0], rem_shift[NUM_W-1]};
    diff  = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        count     <= CNT_W'(NUM_W);
        rem_shift <= num;
        part      <= '0;
        dvs       <= den;
        quo       <= '0;
      end else if (busy) begin
        rem_shift <= rem_shift << 1;
        if (!diff[DEN_W]) begin
          part <= diff;
          quo  <= {quo[NUM_W-2:0], 1'b1};
        end else begin
          part <= trial;
          quo  <= {quo[NUM_W-2:0], 1'b0};
        end
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/gbn_sender_window_rto_aimd.sv
// Top level: Go-Back-N sender with RTT-based timeout and AIMD window.
`default_nettype none
// One request beat in, one status beat out, one request in work at a time.
// Outstanding sequence numbers and send times sit in a single synchronous RAM
// ring (one entry per window slot) read through a registered port and walked
// by a sequencer. Send, loss and unknown types go straight to the status
// register; a timer check reads the oldest entry; an RTT sample probes entries
// in order and, on a match, runs the filter update and timeout (update, sum,
// reciprocal scale by 1/1000, clamp); an ack pops each entry below the acked
// sequence with the same filter update, finds the first entry that stays, then
// takes a slow start step or the congestion avoidance divide (one quotient bit
// a cycle from the bit-serial divider). A full window ack in congestion
// avoidance is the worst case. The status sits in an output register, so the
// next request is accepted while that beat is stalled. No clearing pass after
// reset: the ring is only read at slots that were written.
module gbn_sender_window_rto_aimd #(
  parameter int unsigned WINDOW_DEPTH = gbn_pkg::WindowDepthDefault
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire gbn_pkg::req_t in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output gbn_pkg::rsp_t      out_data,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire gbn_pkg::cfg_t cfg_data
);
  localparam int unsigned AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);
  localparam logic [23:0] CapQ = 24'(WINDOW_DEPTH) << 16;
  // ceil(2^35 / 125): x / 1000 = ((x >> 3) * RecipM) >> 35 for x < 2^30
  localparam logic [28:0] RecipM = 29'd274877907;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_RD    = 10'b0000000010,
    ST_EVAL  = 10'b0000000100,
    ST_RTT1  = 10'b0000001000,
    ST_RTT2  = 10'b0000010000,
    ST_SCALE = 10'b0000100000,
    ST_CLAMP = 10'b0001000000,
    ST_GROW  = 10'b0010000000,
    ST_GDIV  = 10'b0100000000,
    ST_DONE  = 10'b1000000000
  } state_e;

  state_e state;

  // configuration
  logic [19:0] max_to;
  logic [7:0]  add_step;
  logic [3:0]  alpha_sh, beta_sh;

  // protocol state
  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic [31:0]   srtt, rttvar;
  logic [19:0]   rto;
  logic [23:0]   cwnd, ssthresh;
  logic          slow;

  // request context
  gbn_pkg::req_t req;
  logic [CW-1:0] probe;
  logic          resend_v;
  logic [15:0]   resend_s;
  logic          dropped;
  logic [31:0]   sample;

  // ring RAM
  logic [47:0]   ring [WINDOW_DEPTH];
  logic          ring_we;
  logic [AW-1:0] ring_wa, ring_ra;
  logic [47:0]   ring_wd, ring_rd;

  always_ff @(posedge clk) begin
    if (ring_we) ring[ring_wa] <= ring_wd;
    ring_rd <= ring[ring_ra];
  end

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h,
                                          input logic [CW-1:0] k);
    logic [CW:0] s;
    s = {{(CW+1-AW){1'b0}}, h} + {1'b0, k};
    if (s >= (CW+1)'(WINDOW_DEPTH)) s = s - (CW+1)'(WINDOW_DEPTH);
    return s[AW-1:0];
  endfunction

  // divider for the congestion avoidance step
  logic        div_start, div_done;
  logic [39:0] div_num, div_quo;
  logic [23:0] div_den;

  gbn_divu #(.NUM_W(40), .DEN_W(24)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  assign div_num = {add_step, 32'b0};
  assign div_den = (cwnd == '0) ? 24'd1 : cwnd;

  logic [15:0] rd_seq;
  logic [31:0] rd_time, elapsed;
  assign rd_seq  = ring_rd[47:32];
  assign rd_time = ring_rd[31:0];
  assign elapsed = req.now_us - rd_time;

  // floor(elapsed / 1000) >= rto  <=>  elapsed >= rto * 1000
  logic [31:0] rto_us;
  logic        expired;
  assign rto_us  = {12'b0, rto} * 32'd1000;
  assign expired = (elapsed >= rto_us);

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE) && !in_valid;

  // RTT filter arithmetic
  logic [31:0] diff_abs;
  logic [34:0] rto_sum;
  logic [20:0] max_plus;
  logic [30:0] rto_lim;
  logic        rto_over;
  logic [26:0] rto_y;
  logic [55:0] rto_prod;
  logic [19:0] rto_q;
  assign diff_abs = (sample >= srtt) ? sample - srtt : srtt - sample;
  assign rto_sum  = {3'b0, srtt} + {1'b0, rttvar, 2'b0};
  // quotient exceeds max_to once the sum reaches (max_to + 1) * 1000
  assign max_plus = {1'b0, max_to} + 21'd1;
  assign rto_lim  = {10'b0, max_plus} * 31'd1000;
  assign rto_q    = rto_prod[54:35];

  logic [7:0] win_floor;
  always_comb begin
    if (cwnd[23:16] > 8'(WINDOW_DEPTH)) win_floor = 8'(WINDOW_DEPTH);
    else win_floor = cwnd[23:16];
  end

  logic [24:0] grown;
  assign grown = {1'b0, cwnd} + {1'b0, div_quo[23:0]};

  always_comb begin
    ring_we   = 1'b0;
    ring_wa   = slot(head, count);
    ring_wd   = {req.seq_value, req.now_us};
    ring_ra   = slot(head, probe);
    div_start = 1'b0;
    if (state == ST_IDLE && in_valid && !in_stall) begin
      ring_ra = slot(head, '0);
    end
    if (state == ST_IDLE && in_valid && !in_stall &&
        in_data.req_type == gbn_pkg::REQ_SEND &&
        count < CW'(WINDOW_DEPTH)) begin
      ring_we = 1'b1;
      ring_wd = {in_data.seq_value, in_data.now_us};
    end
    if (state == ST_EVAL && req.req_type == gbn_pkg::REQ_TIMER && expired) begin
      ring_we = 1'b1;
      ring_wa = head;
      ring_wd = {rd_seq, req.now_us};
    end
    if (state == ST_GROW && !(slow && cwnd < ssthresh)) div_start = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      max_to    <= 20'd60000;
      add_step  <= 8'd1;
      alpha_sh  <= 4'd3;
      beta_sh   <= 4'd2;
      head      <= '0;
      count     <= '0;
      srtt      <= 32'd1000000;
      rttvar    <= 32'd500000;
      rto       <= 20'd1000;
      cwnd      <= gbn_pkg::QOne;
      ssthresh  <= 24'd16 << 16;
      slow      <= 1'b1;
    end else begin
      // beat taken and no new status loading this cycle
      if (out_valid && !out_stall && state != ST_DONE) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            case (cfg_data.index)
              gbn_pkg::CFG_INIT_TIMEOUT: begin
                srtt    <= 32'(cfg_data.data[19:0]) * 32'd1000;
                rttvar  <= 32'(cfg_data.data[19:0]) * 32'd500;
                rto     <= (cfg_data.data[19:0] == '0) ? 20'd1 : cfg_data.data[19:0];
              end
              gbn_pkg::CFG_MAX_TIMEOUT: max_to <= cfg_data.data[19:0];
              gbn_pkg::CFG_SSTHRESH: ssthresh <= {cfg_data.data[7:0], 16'b0};
              gbn_pkg::CFG_ADD_STEP: add_step <= cfg_data.data[7:0];
              gbn_pkg::CFG_ALPHA:    alpha_sh <= cfg_data.data[3:0];
              gbn_pkg::CFG_BETA:     beta_sh  <= cfg_data.data[3:0];
              default: ;
            endcase
          end
          if (in_valid && !in_stall) begin
            req      <= in_data;
            probe    <= '0;
            resend_v <= 1'b0;
            resend_s <= '0;
            dropped  <= 1'b0;
            case (in_data.req_type)
              gbn_pkg::REQ_SEND: begin
                if (count < CW'(WINDOW_DEPTH)) count <= count + 1'b1;
                else dropped <= 1'b1;
                state <= ST_DONE;
              end
              gbn_pkg::REQ_LOSS: begin
                ssthresh <= cwnd >> 1;
                cwnd     <= ((cwnd >> 1) < gbn_pkg::QOne) ? gbn_pkg::QOne : cwnd >> 1;
                slow     <= 1'b0;
                state    <= ST_DONE;
              end
              gbn_pkg::REQ_ACK, gbn_pkg::REQ_TIMER, gbn_pkg::REQ_RTT:
                state <= ST_RD;
              default: state <= ST_DONE;
            endcase
          end
        end
        ST_RD: begin
          if (probe >= count) begin
            state <= (req.req_type == gbn_pkg::REQ_ACK) ? ST_GROW : ST_DONE;
          end else begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          case (req.req_type)
            gbn_pkg::REQ_TIMER: begin
              if (expired) begin
                resend_v <= 1'b1;
                resend_s <= rd_seq;
              end
              state <= ST_DONE;
            end
            gbn_pkg::REQ_ACK: begin
              if (rd_seq < req.seq_value) begin
                sample  <= elapsed;
                head    <= slot(head, CW'(1));
                count   <= count - 1'b1;
                state   <= ST_RTT1;
              end else begin
                state <= ST_GROW;
              end
            end
            default: begin
              if (rd_seq == req.seq_value) begin
                sample <= elapsed;
                state  <= ST_RTT1;
              end else begin
                probe <= probe + 1'b1;
                state <= ST_RD;
              end
            end
          endcase
        end
        ST_RTT1: begin
          if (srtt == '0) begin
            srtt   <= sample;
            rttvar <= sample >> 1;
          end else begin
            rttvar <= rttvar - (rttvar >> beta_sh) + (diff_abs >> beta_sh);
            srtt   <= srtt - (srtt >> alpha_sh) + (sample >> alpha_sh);
          end
          state <= ST_RTT2;
        end
        ST_RTT2: begin
          rto_over <= (rto_sum >= {4'b0, rto_lim});
          rto_y    <= rto_sum[29:3];
          state    <= ST_SCALE;
        end
        ST_SCALE: begin
          rto_prod <= {29'b0, rto_y} * {27'b0, RecipM};
          state    <= ST_CLAMP;
        end
        ST_CLAMP: begin
          if (rto_over) rto <= (max_to == '0) ? 20'd1 : max_to;
          else rto <= (rto_q == '0) ? 20'd1 : rto_q;
          probe <= '0;
          state <= (req.req_type == gbn_pkg::REQ_ACK) ? ST_RD : ST_DONE;
        end
        ST_GROW: begin
          if (slow && cwnd < ssthresh) begin
            cwnd  <= ((cwnd + gbn_pkg::QOne) > CapQ || cwnd > CapQ) ? CapQ
                   : cwnd + gbn_pkg::QOne;
            state <= ST_DONE;
          end else begin
            slow  <= 1'b0;
            state <= ST_GDIV;
          end
        end
        ST_GDIV: begin
          if (div_done) begin
            if (div_quo[39:24] != '0 || grown > {1'b0, CapQ}) cwnd <= CapQ;
            else cwnd <= grown[23:0];
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid               <= 1'b1;
            out_data.may_send       <= ({{(8-CW){1'b0}}, count} < cwnd[23:16]) &&
                                       (count < CW'(WINDOW_DEPTH));
            out_data.window_now     <= win_floor;
            out_data.resend_valid   <= resend_v;
            out_data.resend_seq     <= resend_s;
            out_data.timeout_now_ms <= rto;
            out_data.cwnd_fixed     <= cwnd;
            out_data.slow_start_on  <= slow;
            out_data.held_count     <= 8'(count);
            out_data.send_dropped   <= dropped;
            state                   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/gbn_checker.sv
// Checker: port-level properties of the Go-Back-N sender, bound to the top.
`default_nettype none
module gbn_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire gbn_pkg::rsp_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");
  a_window_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.window_now <= 8'd255 && out_data.cwnd_fixed >= 24'h010000)
    else $error("window below one packet");
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.send_dropped |-> !out_data.may_send)
    else $error("drop reported while window open");
  a_resend_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.resend_valid |-> out_data.resend_seq == 16'd0)
    else $error("resend sequence without resend");
  a_timeout_nz: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.timeout_now_ms != 20'd0)
    else $error("zero timeout");
endmodule

bind gbn_sender_window_rto_aimd gbn_checker u_chk (
  .clk(clk), .rst(rst),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire

FILE: tb/tb_top.sv
// Testbench for the Go-Back-N sender: directed and random requests checked against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

  localparam int Depth = 16;
  localparam int ExpDepth = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  gbn_pkg::req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  gbn_pkg::rsp_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  gbn_pkg::cfg_t cfg_data = '0;

  always #6 clk = ~clk;

  gbn_sender_window_rto_aimd #(.WINDOW_DEPTH(Depth)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // ---------------------------------------------------------------------
  // Predictor state: a private copy of the sender's registers and ring.
  // ---------------------------------------------------------------------
  logic [19:0] m_init_to, m_max_to;
  logic [7:0]  m_ssth_cfg, m_step;
  logic [3:0]  m_alpha, m_beta;
  logic [15:0] m_seq [Depth];
  logic [31:0] m_sent [Depth];
  int unsigned m_head, m_count;
  logic [31:0] m_srtt, m_rttvar;
  logic [19:0] m_rto;
  logic [23:0] m_cwnd, m_ssth;
  logic        m_slow;

  // expected status beats, oldest at exp_rd
  gbn_pkg::rsp_t exp_ring [ExpDepth];
  int unsigned exp_wr = 0;
  int unsigned exp_rd = 0;
  int   n_fail = 0;
  int   send_idle = 0;   // percent of cycles the request side idles
  int   recv_idle = 0;   // percent of cycles the status side stalls
  logic [31:0] clock_us = 0;

  function automatic void reseed_rtt();
    m_srtt   = 32'(m_init_to * 1000);
    m_rttvar = 32'(m_init_to * 500);
    m_rto    = (m_init_to != 0) ? m_init_to : 20'd1;
  endfunction

  function automatic void predict_reset();
    m_init_to = 1000; m_max_to = 60000; m_ssth_cfg = 16; m_step = 1;
    m_alpha = 3; m_beta = 2;
    m_head = 0; m_count = 0;
    reseed_rtt();
    m_cwnd = gbn_pkg::QOne;
    m_ssth = {m_ssth_cfg, 16'h0};
    m_slow = 1'b1;
  endfunction

  // Fold one round-trip sample into smoothed RTT, variance and timeout.
  function automatic void fold_rtt(logic [31:0] s);
    logic [31:0] diff;
    logic [63:0] rto;
    if (m_srtt == 0) begin
      m_srtt = s;
      m_rttvar = s >> 1;
    end else begin
      diff = (s >= m_srtt) ? s - m_srtt : m_srtt - s;
      m_rttvar = 32'(64'(m_rttvar) - (m_rttvar >> m_beta) + (diff >> m_beta));
      m_srtt = 32'(64'(m_srtt) - (m_srtt >> m_alpha) + (s >> m_alpha));
    end
    rto = (64'(m_srtt) + 4 * 64'(m_rttvar)) / 1000;
    if (rto > m_max_to) rto = m_max_to;
    if (rto < 1) rto = 1;
    m_rto = rto[19:0];
  endfunction

  function automatic void grow_cwnd();
    logic [63:0] c;
    c = m_cwnd;
    if (m_slow && c < m_ssth) begin
      c += 64'(gbn_pkg::QOne);
    end else begin
      m_slow = 1'b0;
      c += (64'(m_step) << 32) / ((c != 0) ? c : 64'd1);
    end
    if (c > (64'(Depth) << 16)) c = 64'(Depth) << 16;
    m_cwnd = c[23:0];
  endfunction

  function automatic gbn_pkg::rsp_t predict_status(gbn_pkg::req_t r);
    gbn_pkg::rsp_t o;
    int unsigned k, slot;
    logic [31:0] age;
    o = '0;
    case (r.req_type)
      gbn_pkg::REQ_SEND: begin
        if (m_count >= Depth) o.send_dropped = 1'b1;
        else begin
          slot = (m_head + m_count) % Depth;
          m_seq[slot] = r.seq_value;
          m_sent[slot] = r.now_us;
          m_count++;
        end
      end
      gbn_pkg::REQ_ACK: begin
        while (m_count > 0 && m_seq[m_head] < r.seq_value) begin
          fold_rtt(r.now_us - m_sent[m_head]);
          m_head = (m_head + 1) % Depth;
          m_count--;
        end
        grow_cwnd();
      end
      gbn_pkg::REQ_TIMER: begin
        if (m_count > 0) begin
          age = (r.now_us - m_sent[m_head]) / 1000;
          if (age >= m_rto) begin
            o.resend_valid = 1'b1;
            o.resend_seq = m_seq[m_head];
            m_sent[m_head] = r.now_us;
          end
        end
      end
      gbn_pkg::REQ_LOSS: begin
        m_ssth = m_cwnd >> 1;
        m_cwnd = m_ssth;
        m_slow = 1'b0;
        if (m_cwnd < gbn_pkg::QOne) m_cwnd = gbn_pkg::QOne;
      end
      gbn_pkg::REQ_RTT: begin
        for (k = 0; k < m_count; k++) begin
          slot = (m_head + k) % Depth;
          if (m_seq[slot] == r.seq_value) begin
            fold_rtt(r.now_us - m_sent[slot]);
            break;
          end
        end
      end
      default: ;  // unknown types change nothing
    endcase
    o.window_now = ((m_cwnd >> 16) > Depth) ? 8'(Depth) : 8'(m_cwnd >> 16);
    o.may_send = (m_count < (m_cwnd >> 16)) && (m_count < Depth);
    o.timeout_now_ms = m_rto;
    o.cwnd_fixed = m_cwnd;
    o.slow_start_on = m_slow;
    o.held_count = 8'(m_count);
    return o;
  endfunction

  // ---------------------------------------------------------------------
  // Request driver: one beat per call, random idle ahead of it. Valid stays
  // up between back-to-back beats; idle cycles and drain() drop it.
  // ---------------------------------------------------------------------
  task automatic send_req(logic [2:0] kind, logic [15:0] seq, logic [31:0] now);
    gbn_pkg::req_t r;
    r.req_type = kind; r.seq_value = seq; r.now_us = now;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    exp_ring[exp_wr % ExpDepth] = predict_status(r);
    exp_wr++;
  endtask

  task automatic write_reg(gbn_pkg::cfg_e idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_data <= '{index: idx, data: val};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      gbn_pkg::CFG_INIT_TIMEOUT: begin m_init_to = val[19:0]; reseed_rtt(); end
      gbn_pkg::CFG_MAX_TIMEOUT:  m_max_to = val[19:0];
      gbn_pkg::CFG_SSTHRESH:     begin m_ssth_cfg = val[7:0]; m_ssth = {val[7:0], 16'h0}; end
      gbn_pkg::CFG_ADD_STEP:     m_step = val[7:0];
      gbn_pkg::CFG_ALPHA:        m_alpha = val[3:0];
      gbn_pkg::CFG_BETA:         m_beta = val[3:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Wait for every status beat to drain; acks with many pops can run long.
  task automatic drain();
    in_valid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  // Status checker: stall at random, compare each beat against the oldest prediction.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (exp_wr == exp_rd) begin
          $error("unexpected status beat");
          n_fail++;
        end else begin : cmp
          gbn_pkg::rsp_t e;
          e = exp_ring[exp_rd % ExpDepth];
          exp_rd++;
          if (out_data.may_send !== e.may_send) begin
            $error("may_send exp %0d got %0d", e.may_send, out_data.may_send); n_fail++; end
          if (out_data.window_now !== e.window_now) begin
            $error("window_now exp %0d got %0d", e.window_now, out_data.window_now); n_fail++; end
          if (out_data.resend_valid !== e.resend_valid) begin
            $error("resend_valid exp %0d got %0d", e.resend_valid, out_data.resend_valid);
            n_fail++; end
          if (out_data.resend_seq !== e.resend_seq) begin
            $error("resend_seq exp %0d got %0d", e.resend_seq, out_data.resend_seq); n_fail++; end
          if (out_data.timeout_now_ms !== e.timeout_now_ms) begin
            $error("timeout_now_ms exp %0d got %0d", e.timeout_now_ms, out_data.timeout_now_ms);
            n_fail++; end
          if (out_data.cwnd_fixed !== e.cwnd_fixed) begin
            $error("cwnd_fixed exp %0h got %0h", e.cwnd_fixed, out_data.cwnd_fixed); n_fail++; end
          if (out_data.slow_start_on !== e.slow_start_on) begin
            $error("slow_start_on exp %0d got %0d", e.slow_start_on, out_data.slow_start_on);
            n_fail++; end
          if (out_data.held_count !== e.held_count) begin
            $error("held_count exp %0d got %0d", e.held_count, out_data.held_count); n_fail++; end
          if (out_data.send_dropped !== e.send_dropped) begin
            $error("send_dropped exp %0d got %0d", e.send_dropped, out_data.send_dropped);
            n_fail++; end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Extremes: fill past full, unknown types, timer on empty, absent sample.
  task automatic test_directed();
    send_req(gbn_pkg::REQ_TIMER, 16'h0, 32'h0);          // timer on empty store
    send_req(gbn_pkg::REQ_RTT, 16'hFFFF, 32'hFFFF_FFFF); // sample on empty store
    send_req(3'd5, 16'hFFFF, 32'hFFFF_FFFF);
    send_req(3'd7, 16'h5555, 32'hAAAA_AAAA);
    for (int i = 0; i < 17; i++)               // last send hits a full store
      send_req(gbn_pkg::REQ_SEND, (i == 0) ? 16'h0 : 16'(i * 4000), 32'hFFFF_F000 + i);
    send_req(gbn_pkg::REQ_TIMER, 16'h0, 32'h0100_0000);  // oldest expired across wrap
    send_req(gbn_pkg::REQ_RTT, 16'(8000), 32'h0000_2000); // present sequence
    send_req(gbn_pkg::REQ_ACK, 16'hFFFF, 32'h0000_4000);  // pops every held entry, all below 0xFFFF
    send_req(gbn_pkg::REQ_LOSS, 16'h0, 32'h0);
    send_req(gbn_pkg::REQ_ACK, 16'h0, 32'h0);            // window grows with no pop
  endtask

  // Config extremes: each register at low and high, zero timeout and shifts.
  task automatic test_config(int phase);
    drain();
    case (phase)
      0: begin
        write_reg(gbn_pkg::CFG_INIT_TIMEOUT, 0); write_reg(gbn_pkg::CFG_MAX_TIMEOUT, 1);
        write_reg(gbn_pkg::CFG_SSTHRESH, 1); write_reg(gbn_pkg::CFG_ADD_STEP, 255);
        write_reg(gbn_pkg::CFG_ALPHA, 0); write_reg(gbn_pkg::CFG_BETA, 0);
      end
      1: begin
        write_reg(gbn_pkg::CFG_INIT_TIMEOUT, 20'hFFFFF);
        write_reg(gbn_pkg::CFG_MAX_TIMEOUT, 20'hFFFFF);
        write_reg(gbn_pkg::CFG_SSTHRESH, 255); write_reg(gbn_pkg::CFG_ADD_STEP, 1);
        write_reg(gbn_pkg::CFG_ALPHA, 8); write_reg(gbn_pkg::CFG_BETA, 8);
      end
      default: begin
        write_reg(gbn_pkg::CFG_INIT_TIMEOUT, $urandom_range(1, 50));
        write_reg(gbn_pkg::CFG_MAX_TIMEOUT, $urandom_range(1, 400));
        write_reg(gbn_pkg::CFG_SSTHRESH, $urandom_range(1, 20));
        write_reg(gbn_pkg::CFG_ADD_STEP, $urandom_range(1, 255));
        write_reg(gbn_pkg::CFG_ALPHA, $urandom_range(0, 8));
        write_reg(gbn_pkg::CFG_BETA, $urandom_range(0, 8));
        write_reg(gbn_pkg::cfg_e'(3'd6), 32'hFFFF_FFFF);  // index past the list, ignored
      end
    endcase
  endtask

  // Mostly a well-formed flow: sends with rising sequence, acks, timers,
  // samples of live sequences, occasional loss and random noise.
  task automatic test_random(int n);
    logic [15:0] next_seq;
    int r;
    next_seq = 16'($urandom);
    for (int i = 0; i < n; i++) begin
      clock_us += $urandom_range(0, 300000);
      r = $urandom_range(99);
      if (r < 35) begin
        send_req(gbn_pkg::REQ_SEND, next_seq, clock_us);
        next_seq += 16'($urandom_range(1, 3));
      end else if (r < 55)
        send_req(gbn_pkg::REQ_ACK, next_seq - 16'($urandom_range(0, 20)), clock_us);
      else if (r < 70)
        send_req(gbn_pkg::REQ_TIMER, 16'($urandom), clock_us);
      else if (r < 80)
        send_req(gbn_pkg::REQ_RTT, next_seq - 16'($urandom_range(0, 20)), clock_us);
      else if (r < 85)
        send_req(gbn_pkg::REQ_LOSS, 16'($urandom), clock_us);
      else
        send_req(3'($urandom), 16'($urandom), $urandom);
    end
  endtask

  initial begin
    predict_reset();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle = 28; recv_idle = 65;
    test_directed();
    test_config(0);
    test_random(150);
    // Hold-off: let every outstanding status arrive before resuming.
    drain();
    test_config(1);
    test_random(150);

    send_idle = 65; recv_idle = 28;
    test_config(2);
    test_random(350);

    send_idle = 0; recv_idle = 0;
    test_config(3);
    test_random(450);

    drain();
    if (n_fail == 0) $display("gbn_sender_window_rto_aimd regression: pass");
    else $display("gbn_sender_window_rto_aimd regression: fail");
    $finish;
  end

  initial begin
    #100ms;
    $display("gbn_sender_window_rto_aimd regression: fail");
    $finish;
  end
endmodule
`default_nettype wire
